FILE: sv/ept_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ept_pkg: shared types and constants of the encoder position tracker
// Request and configuration structures, register indexes, limit bit
// positions and reset values used by the top level and its front, queue and back parts.
// ----------------------------------------------------------------------------
package ept_pkg;

    localparam int RAW_MAX_BITS = 32;
    localparam int WRAP_BITS    = 16;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_BITS    = 2;
    localparam int LEFT_BASE    = 3;

    localparam logic KIND_ENCODER = 1'b0;
    localparam logic KIND_PORT    = 1'b1;

    localparam logic CARD_RIGHT = 1'b0;
    localparam logic CARD_LEFT  = 1'b1;

    localparam int LIMIT_SHOULDER_BIT = 2;
    localparam int LIMIT_ELBOW_BIT    = 3;

    localparam logic [7:0] REG_WRAP_THRESHOLD = 8'd0;
    localparam logic [7:0] REG_INVERT_MASK    = 8'd1;
    localparam logic [7:0] REG_HOME_SHOULDER  = 8'd2;
    localparam logic [7:0] REG_HOME_ELBOW     = 8'd3;

    localparam logic [15:0] WRAP_THRESHOLD_RESET = 16'd62000;
    localparam logic [5:0]  INVERT_MASK_RESET    = 6'd2;
    localparam logic [23:0] HOME_SHOULDER_RESET  = 24'd194460;
    localparam logic [23:0] HOME_ELBOW_RESET     = 24'd136246;
    localparam logic [7:0]  PORT_RESET           = 8'hFF;

    typedef struct packed {
        logic                    kind;
        logic                    chan_ok;
        logic [2:0]              channel;
        logic                    card;
        logic [RAW_MAX_BITS-1:0] raw;
        logic [7:0]              port;
    } cmd_t;

    typedef struct packed {
        logic [15:0] wrap_threshold;
        logic [5:0]  invert_mask;
        logic [23:0] home_shoulder;
        logic [23:0] home_elbow;
    } cfg_t;

endpackage
`default_nettype wire

FILE: sv/encoder_position_tracker_homing.sv
`default_nettype none
// ----------------------------------------------------------------------------
// encoder_position_tracker_homing: six-joint encoder tracker with homing
// Extends raw encoder counts by wrap counting, applies direction and homing
// offset, reports position and velocity, and re-homes joints on limit bytes.
// ----------------------------------------------------------------------------
// The block takes one request per clock while s_ready is high and returns
// one result per request, in order, each after one front register, the
// queue and three back stages. Each part of a channel's state is read and
// written in a single back stage, so requests for the same channel may
// follow each other in consecutive cycles. Configuration is written through
// cfg_wr_en, cfg_index and cfg_wdata; the user must do so only while no
// request is in flight (not enforced). Writes to unknown indexes are dropped.
module encoder_position_tracker_homing #(
    parameter int NUM_CHANNELS  = 6,
    parameter int COUNTER_BITS  = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic                       s_kind,
    input  wire logic [2:0]                 s_channel,
    input  wire logic                       s_card,
    input  wire logic [COUNTER_BITS-1:0]    s_raw_count,
    input  wire logic [7:0]                 s_port_bits,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [2:0]                      m_out_channel,
    output logic signed [POSITION_BITS-1:0] m_position,
    output logic signed [POSITION_BITS-1:0] m_velocity,
    output logic                            m_homed,
    input  wire logic                       cfg_wr_en,
    input  wire logic [7:0]                 cfg_index,
    input  wire logic [23:0]                cfg_wdata
);
    import ept_pkg::*;

    cfg_t cfg_reg;
    cmd_t front_cmd;
    cmd_t queue_cmd;
    logic front_valid;
    logic front_ready;
    logic queue_valid;
    logic queue_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.wrap_threshold <= WRAP_THRESHOLD_RESET;
            cfg_reg.invert_mask    <= INVERT_MASK_RESET;
            cfg_reg.home_shoulder  <= HOME_SHOULDER_RESET;
            cfg_reg.home_elbow     <= HOME_ELBOW_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WRAP_THRESHOLD: begin
                    cfg_reg.wrap_threshold <= cfg_wdata[15:0];
                end
                REG_INVERT_MASK: begin
                    cfg_reg.invert_mask <= cfg_wdata[5:0];
                end
                REG_HOME_SHOULDER: begin
                    cfg_reg.home_shoulder <= cfg_wdata;
                end
                REG_HOME_ELBOW: begin
                    cfg_reg.home_elbow <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    ept_front #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_kind      (s_kind),
        .s_channel   (s_channel),
        .s_card      (s_card),
        .s_raw_count (s_raw_count),
        .s_port_bits (s_port_bits),
        .cmd_valid   (front_valid),
        .cmd_ready   (front_ready),
        .cmd         (front_cmd)
    );

    ept_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_cmd    (front_cmd),
        .out_valid (queue_valid),
        .out_ready (queue_ready),
        .out_cmd   (queue_cmd)
    );

    ept_back #(
        .NUM_CHANNELS  (NUM_CHANNELS),
        .COUNTER_BITS  (COUNTER_BITS),
        .POSITION_BITS (POSITION_BITS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .cmd_valid     (queue_valid),
        .cmd_ready     (queue_ready),
        .cmd           (queue_cmd),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_position    (m_position),
        .m_velocity    (m_velocity),
        .m_homed       (m_homed)
    );

endmodule
`default_nettype wire

FILE: sv/ept_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ept_front: request intake and classification
// Registers each accepted request, checks the channel range and packs the
// fields into a queue entry.
// ----------------------------------------------------------------------------
module ept_front #(
    parameter int NUM_CHANNELS = 6,
    parameter int COUNTER_BITS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic                    s_kind,
    input  wire logic [2:0]              s_channel,
    input  wire logic                    s_card,
    input  wire logic [COUNTER_BITS-1:0] s_raw_count,
    input  wire logic [7:0]              s_port_bits,
    output logic                         cmd_valid,
    input  wire logic                    cmd_ready,
    output ept_pkg::cmd_t                cmd
);
    import ept_pkg::*;

    logic cmd_valid_reg;
    cmd_t cmd_reg;
    logic accept;

    assign s_ready   = !cmd_valid_reg || cmd_ready;
    assign accept    = s_valid && s_ready;
    assign cmd_valid = cmd_valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg <= 1'b0;
        end else if (accept) begin
            cmd_valid_reg <= 1'b1;
        end else if (cmd_ready) begin
            cmd_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg.kind    <= s_kind;
            cmd_reg.chan_ok <= (32'(s_channel) < 32'(NUM_CHANNELS));
            cmd_reg.channel <= s_channel;
            cmd_reg.card    <= s_card;
            cmd_reg.raw     <= RAW_MAX_BITS'(s_raw_count);
            cmd_reg.port    <= s_port_bits;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ept_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ept_queue: request queue between front and back
// Small first-in first-out buffer so that front and back stall independently.
// ----------------------------------------------------------------------------
module ept_queue (
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  ept_pkg::cmd_t in_cmd,
    output logic         out_valid,
    input  wire logic    out_ready,
    output ept_pkg::cmd_t out_cmd
);
    import ept_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 push;
    logic                 pop;

    assign in_ready  = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QPTR_BITS+1)'(QUEUE_DEPTH))
        else $error("queue fill count above depth");

    a_count_push: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue fill count missed a push");

endmodule
`default_nettype wire

FILE: sv/ept_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ept_back: count extension, offset correction and homing
// Stage one extends the raw count by the wrap counter and tracks limit bytes,
// stage two applies direction and homing offset or re-homes joints, stage
// three forms the velocity into the output register.
// ----------------------------------------------------------------------------
module ept_back #(
    parameter int NUM_CHANNELS  = 6,
    parameter int COUNTER_BITS  = 16,
    parameter int POSITION_BITS = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  ept_pkg::cfg_t                 cfg,
    input  wire logic                     cmd_valid,
    output logic                          cmd_ready,
    input  ept_pkg::cmd_t                 cmd,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [2:0]                    m_out_channel,
    output logic signed [POSITION_BITS-1:0] m_position,
    output logic signed [POSITION_BITS-1:0] m_velocity,
    output logic                          m_homed
);
    import ept_pkg::*;

    localparam int CHW   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int DW    = ((COUNTER_BITS > WRAP_BITS) ? COUNTER_BITS : WRAP_BITS) + 2;
    localparam int EXT_W = POSITION_BITS + WRAP_BITS + COUNTER_BITS;
    localparam bit RIGHT_SH_OK = (NUM_CHANNELS > 0);
    localparam bit RIGHT_EL_OK = (NUM_CHANNELS > 1);
    localparam bit LEFT_SH_OK  = (NUM_CHANNELS > LEFT_BASE);
    localparam bit LEFT_EL_OK  = (NUM_CHANNELS > LEFT_BASE + 1);

    // channel state
    logic [COUNTER_BITS-1:0]  last_raw_reg      [NUM_CHANNELS];
    logic [WRAP_BITS-1:0]     wrap_count_reg    [NUM_CHANNELS];
    logic [POSITION_BITS-1:0] home_offset_reg   [NUM_CHANNELS];
    logic [POSITION_BITS-1:0] last_position_reg [NUM_CHANNELS];
    logic [7:0]               last_port_reg     [2];

    logic adv;

    // stage one
    logic [31:0]              ch_wide;
    logic [CHW-1:0]           ch_idx;
    logic [COUNTER_BITS-1:0]  raw1;
    logic                     enc1;
    logic                     port1;
    logic signed [DW-1:0]     diff;
    logic signed [DW-1:0]     thr;
    logic [WRAP_BITS-1:0]     wrap_cur;
    logic [WRAP_BITS-1:0]     wrap_next;
    logic [EXT_W-1:0]         ext_wide;
    logic [7:0]               mask8;
    logic                     changed;
    logic                     sh_ok;
    logic                     el_ok;

    logic                     p1_valid_reg;
    logic                     p1_kind_reg;
    logic                     p1_chan_ok_reg;
    logic [2:0]               p1_channel_reg;
    logic [CHW-1:0]           p1_idx_reg;
    logic [POSITION_BITS-1:0] p1_ext_reg;
    logic                     p1_inv_reg;
    logic                     p1_card_reg;
    logic                     p1_do_sh_reg;
    logic                     p1_do_el_reg;

    // stage two
    logic                     enc2;
    logic                     port2;
    logic [POSITION_BITS-1:0] ext_sel;
    logic [POSITION_BITS-1:0] pos_next;
    logic [31:0]              js_wide;
    logic [31:0]              je_wide;
    logic [CHW-1:0]           js;
    logic [CHW-1:0]           je;
    logic [POSITION_BITS-1:0] home_sh;
    logic [POSITION_BITS-1:0] home_el;
    logic [POSITION_BITS-1:0] sh_off_next;
    logic [POSITION_BITS-1:0] el_off_next;

    logic                     p2_valid_reg;
    logic [2:0]               p2_channel_reg;
    logic [POSITION_BITS-1:0] p2_pos_reg;
    logic [POSITION_BITS-1:0] p2_prev_reg;
    logic                     p2_homed_reg;

    // output register
    logic                     m_valid_reg;
    logic [2:0]               m_channel_reg;
    logic [POSITION_BITS-1:0] m_position_reg;
    logic [POSITION_BITS-1:0] m_velocity_reg;
    logic                     m_homed_reg;

    assign adv       = !m_valid_reg || m_ready;
    assign cmd_ready = adv;

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_channel_reg;
    assign m_position    = $signed(m_position_reg);
    assign m_velocity    = $signed(m_velocity_reg);
    assign m_homed       = m_homed_reg;

    always_comb begin
        ch_wide  = 32'(cmd.channel);
        ch_idx   = ch_wide[CHW-1:0];
        raw1     = cmd.raw[COUNTER_BITS-1:0];
        enc1     = cmd_valid && (cmd.kind == KIND_ENCODER) && cmd.chan_ok;
        port1    = cmd_valid && (cmd.kind == KIND_PORT);
        diff     = $signed(DW'(raw1)) - $signed(DW'(last_raw_reg[ch_idx]));
        thr      = $signed(DW'(cfg.wrap_threshold));
        wrap_cur = wrap_count_reg[ch_idx];
        if (diff < -thr) begin
            wrap_next = wrap_cur + 1'b1;
        end else if (diff > thr) begin
            wrap_next = wrap_cur - 1'b1;
        end else begin
            wrap_next = wrap_cur;
        end
        ext_wide = {{POSITION_BITS{wrap_next[WRAP_BITS-1]}}, wrap_next, raw1};
        mask8    = {2'b00, cfg.invert_mask};
        changed  = (cmd.port != last_port_reg[cmd.card]);
        sh_ok    = (cmd.card == CARD_LEFT) ? LEFT_SH_OK : RIGHT_SH_OK;
        el_ok    = (cmd.card == CARD_LEFT) ? LEFT_EL_OK : RIGHT_EL_OK;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                last_raw_reg[i]   <= '0;
                wrap_count_reg[i] <= '0;
            end
            last_port_reg[0] <= PORT_RESET;
            last_port_reg[1] <= PORT_RESET;
        end else if (adv) begin
            if (enc1) begin
                last_raw_reg[ch_idx]   <= raw1;
                wrap_count_reg[ch_idx] <= wrap_next;
            end
            if (port1) begin
                last_port_reg[cmd.card] <= cmd.port;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else if (adv) begin
            p1_valid_reg <= cmd_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && cmd_valid) begin
            p1_kind_reg    <= cmd.kind;
            p1_chan_ok_reg <= cmd.chan_ok;
            p1_channel_reg <= cmd.channel;
            p1_idx_reg     <= ch_idx;
            p1_ext_reg     <= ext_wide[POSITION_BITS-1:0];
            p1_inv_reg     <= mask8[cmd.channel];
            p1_card_reg    <= cmd.card;
            p1_do_sh_reg   <= port1 && changed && !cmd.port[LIMIT_SHOULDER_BIT] && sh_ok;
            p1_do_el_reg   <= port1 && changed && !cmd.port[LIMIT_ELBOW_BIT] && el_ok;
        end
    end

    always_comb begin
        enc2     = p1_valid_reg && (p1_kind_reg == KIND_ENCODER) && p1_chan_ok_reg;
        port2    = p1_valid_reg && (p1_kind_reg == KIND_PORT);
        ext_sel  = p1_inv_reg ? ~p1_ext_reg : p1_ext_reg;
        pos_next = ext_sel - home_offset_reg[p1_idx_reg] + POSITION_BITS'(p1_inv_reg);
        js_wide  = (p1_card_reg == CARD_LEFT) ? 32'(LEFT_BASE) : 32'd0;
        je_wide  = js_wide + 32'd1;
        js       = js_wide[CHW-1:0];
        je       = je_wide[CHW-1:0];
        home_sh  = POSITION_BITS'(cfg.home_shoulder);
        home_el  = POSITION_BITS'(cfg.home_elbow);
        if (p1_card_reg == CARD_LEFT) begin
            sh_off_next = home_offset_reg[js] + last_position_reg[js] - home_sh;
            el_off_next = home_offset_reg[je] + last_position_reg[je] - home_el;
        end else begin
            sh_off_next = home_offset_reg[js] + last_position_reg[js] + home_sh;
            el_off_next = home_offset_reg[je] + last_position_reg[je] + home_el;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                home_offset_reg[i]   <= '0;
                last_position_reg[i] <= '0;
            end
        end else if (adv) begin
            if (enc2) begin
                last_position_reg[p1_idx_reg] <= pos_next;
            end
            if (port2 && p1_do_sh_reg) begin
                home_offset_reg[js] <= sh_off_next;
            end
            if (port2 && p1_do_el_reg) begin
                home_offset_reg[je] <= el_off_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p2_valid_reg <= 1'b0;
        end else if (adv) begin
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p1_valid_reg) begin
            p2_channel_reg <= (p1_kind_reg == KIND_ENCODER) ? p1_channel_reg : 3'd0;
            p2_pos_reg     <= enc2 ? pos_next : '0;
            p2_prev_reg    <= enc2 ? last_position_reg[p1_idx_reg] : '0;
            p2_homed_reg   <= port2 && (p1_do_sh_reg || p1_do_el_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && p2_valid_reg) begin
            m_channel_reg  <= p2_channel_reg;
            m_position_reg <= p2_pos_reg;
            m_velocity_reg <= p2_pos_reg - p2_prev_reg;
            m_homed_reg    <= p2_homed_reg;
        end
    end

    a_homed_still: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_homed_reg |-> m_position_reg == '0 && m_velocity_reg == '0
            && m_channel_reg == 3'd0)
        else $error("port result carries motion");

    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(p2_valid_reg))
        else $error("result without a request in the last stage");

    a_rehome_port: assert property (@(posedge aclk) disable iff (!aresetn)
        p1_valid_reg && (p1_do_sh_reg || p1_do_el_reg) |-> p1_kind_reg == KIND_PORT)
        else $error("re-home flagged on an encoder request");

endmodule
`default_nettype wire

FILE: verif/tb_encoder_position_tracker_homing.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_encoder_position_tracker_homing: self-checking bench for the tracker
// Sends encoder readings and limit port bytes through the request channel
// and keeps its own model of the wrap counters, homing offsets and last
// positions. Every result is compared field by field, in order, with the
// model's reading. The sender runs in random bursts and the receiver stalls
// on its own pattern. Directed items cover the reset settings, wrap edges
// and homing, and random phases cover several register settings.
// ----------------------------------------------------------------------------
module tb_encoder_position_tracker_homing;
    import ept_pkg::*;

    localparam int NUM_CH = 6;

    typedef struct packed {
        logic [2:0]         chan;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               homed;
    } reading_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_ENCODER;
    logic [2:0]  s_channel = 3'd0;
    logic        s_card = CARD_RIGHT;
    logic [15:0] s_raw_count = 16'd0;
    logic [7:0]  s_port_bits = 8'hFF;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_out_channel;
    logic signed [31:0] m_position;
    logic signed [31:0] m_velocity;
    logic        m_homed;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_index = 8'd0;
    logic [23:0] cfg_wdata = 24'd0;

    // tracker model state and settings
    logic [15:0] wrap_thr;
    logic [5:0]  invert_sel;
    logic [23:0] shoulder_home;
    logic [23:0] elbow_home;
    logic [15:0] prev_raw [0:NUM_CH-1];
    logic [15:0] wrap_turns [0:NUM_CH-1];
    logic [31:0] home_ofs [0:NUM_CH-1];
    logic [31:0] pos_hist [0:NUM_CH-1];
    logic [7:0]  prev_port [0:1];

    reading_t pending_readings [$];
    int       fail_count = 0;
    int       burst_left = 0;
    int       gap_max = 0;
    int       rx_cycle = 0;
    int       rx_mode = 0;
    int       rx_stall = 0;

    encoder_position_tracker_homing #(
        .NUM_CHANNELS(NUM_CH),
        .COUNTER_BITS(16),
        .POSITION_BITS(32)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_kind(s_kind),
        .s_channel(s_channel),
        .s_card(s_card),
        .s_raw_count(s_raw_count),
        .s_port_bits(s_port_bits),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_channel(m_out_channel),
        .m_position(m_position),
        .m_velocity(m_velocity),
        .m_homed(m_homed),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #8_000_000;
        $display("status: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < 40) begin
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    function automatic void reset_tracker_model();
        wrap_thr      = WRAP_THRESHOLD_RESET;
        invert_sel    = INVERT_MASK_RESET;
        shoulder_home = HOME_SHOULDER_RESET;
        elbow_home    = HOME_ELBOW_RESET;
        for (int i = 0; i < NUM_CH; i++) begin
            prev_raw[i]   = 16'd0;
            wrap_turns[i] = 16'd0;
            home_ofs[i]   = 32'd0;
            pos_hist[i]   = 32'd0;
        end
        prev_port[0] = PORT_RESET;
        prev_port[1] = PORT_RESET;
    endfunction

    // moves the joint's offset so that it reads -home (right) or +home (left)
    function automatic logic rehome_joint(input int joint, input logic [23:0] home,
                                          input logic card);
        logic [31:0] step;
        if (joint >= NUM_CH) begin
            return 1'b0;
        end
        step = (card == CARD_RIGHT) ? {8'h00, home} : -{8'h00, home};
        home_ofs[joint] = home_ofs[joint] + pos_hist[joint] + step;
        return 1'b1;
    endfunction

    function automatic reading_t predict_reading(input logic kind, input logic [2:0] chan,
                                                 input logic card, input logic [15:0] raw,
                                                 input logic [7:0] port);
        reading_t    rd;
        int          diff;
        int          base;
        logic [31:0] ext;
        logic [31:0] pos;
        rd = '0;
        if (kind == KIND_ENCODER) begin
            rd.chan = chan;
            if (chan < NUM_CH) begin
                diff = int'(raw) - int'(prev_raw[chan]);
                if (diff < -int'(wrap_thr)) begin
                    wrap_turns[chan] = wrap_turns[chan] + 16'd1;
                end else if (diff > int'(wrap_thr)) begin
                    wrap_turns[chan] = wrap_turns[chan] - 16'd1;
                end
                prev_raw[chan] = raw;
                ext = {wrap_turns[chan], 16'h0000} + {16'h0000, raw};
                if (invert_sel[chan]) begin
                    ext = -ext;
                end
                pos = ext - home_ofs[chan];
                rd.pos = pos;
                rd.vel = pos - pos_hist[chan];
                pos_hist[chan] = pos;
            end
        end else begin
            base = (card == CARD_LEFT) ? LEFT_BASE : 0;
            if (port != prev_port[card]) begin
                if (!port[LIMIT_SHOULDER_BIT]) begin
                    rd.homed = rd.homed | rehome_joint(base, shoulder_home, card);
                end
                if (!port[LIMIT_ELBOW_BIT]) begin
                    rd.homed = rd.homed | rehome_joint(base + 1, elbow_home, card);
                end
            end
            prev_port[card] = port;
        end
        return rd;
    endfunction

    // one request; entered and left at a rising edge
    task automatic send_request(input logic kind, input logic [2:0] chan, input logic card,
                                input logic [15:0] raw, input logic [7:0] port);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max == 0 || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, gap_max);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_channel   <= chan;
        s_card      <= card;
        s_raw_count <= raw;
        s_port_bits <= port;
        pending_readings.push_back(predict_reading(kind, chan, card, raw, port));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_encoder(input logic [2:0] chan, input logic [15:0] raw);
        send_request(KIND_ENCODER, chan, 1'($urandom), raw, 8'($urandom));
    endtask

    task automatic send_port(input logic card, input logic [7:0] port);
        send_request(KIND_PORT, 3'($urandom), card, 16'($urandom), port);
    endtask

    task automatic send_random_item();
        logic [2:0]  chan;
        logic [15:0] raw;
        logic        card;
        logic [7:0]  port;
        if ($urandom_range(0, 99) < 75) begin
            chan = ($urandom_range(0, 32) == 0) ? 3'($urandom_range(6, 7))
                                                : 3'($urandom_range(0, NUM_CH - 1));
            if (chan < NUM_CH && $urandom_range(0, 9) != 0) begin
                raw = prev_raw[chan] + 16'($urandom_range(0, 6000) - 3000);
            end else begin
                raw = 16'($urandom);
            end
            send_encoder(chan, raw);
        end else begin
            card = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: begin
                    port = prev_port[card];
                end
                1: begin
                    port = 8'($urandom);
                end
                default: begin
                    port = 8'hFF;
                    port[LIMIT_SHOULDER_BIT] = 1'($urandom_range(0, 1));
                    port[LIMIT_ELBOW_BIT]    = 1'($urandom_range(0, 1));
                end
            endcase
            send_port(card, port);
        end
    endtask

    // settle the pipeline before any register write
    task automatic drain_requests();
        s_valid <= 1'b0;
        for (int i = 0; i < 4000 && pending_readings.size() != 0; i++) @(posedge aclk);
        if (pending_readings.size() != 0) begin
            report_mismatch("results never returned", pending_readings.size(), 0);
            pending_readings.delete();
        end
        repeat (8) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [15:0] thr, input logic [5:0] inv,
                                  input logic [23:0] sh, input logic [23:0] el);
        logic [7:0]  idx [0:4];
        logic [23:0] val [0:4];
        idx[0] = REG_WRAP_THRESHOLD; val[0] = {8'($urandom), thr};
        idx[1] = REG_INVERT_MASK;    val[1] = {18'($urandom), inv};
        idx[2] = REG_HOME_SHOULDER;  val[2] = sh;
        idx[3] = REG_HOME_ELBOW;     val[3] = el;
        idx[4] = 8'($urandom_range(4, 255));
        val[4] = 24'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
        wrap_thr      = thr;
        invert_sel    = inv;
        shoulder_home = sh;
        elbow_home    = el;
    endtask

    task automatic test_directed();
        gap_max = 0;
        send_encoder(3'd0, 16'd0);
        send_encoder(3'd0, 16'hFFFF);
        send_encoder(3'd0, 16'd0);
        send_encoder(3'd1, 16'd1000);
        send_encoder(3'd5, 16'h8000);
        send_encoder(3'd6, 16'd1234);
        send_encoder(3'd7, 16'hFFFF);
        send_encoder(3'd2, 16'd62000);
        send_encoder(3'd2, 16'd0);
        send_encoder(3'd2, 16'd62001);
        send_encoder(3'd2, 16'd0);
        send_port(CARD_RIGHT, 8'hFB);
        send_port(CARD_RIGHT, 8'hFB);
        send_port(CARD_RIGHT, 8'hF3);
        send_encoder(3'd0, 16'd100);
        send_encoder(3'd1, 16'd0);
        send_port(CARD_LEFT, 8'hF7);
        send_port(CARD_LEFT, 8'hFF);
        send_encoder(3'd4, 16'hFFFF);
        send_port(CARD_LEFT, 8'h00);
        send_encoder(3'd3, 16'd7);
        send_encoder(3'd4, 16'd0);
        send_port(CARD_RIGHT, 8'h0C);
        send_encoder(3'd1, 16'hFFFF);
        drain_requests();
    endtask

    task automatic test_register_extremes();
        apply_settings(16'd0, 6'h3F, 24'hFFFFFF, 24'hFFFFFF);
        gap_max = 6;
        repeat (150) send_random_item();
        drain_requests();
        apply_settings(16'hFFFF, 6'h00, 24'd0, 24'd0);
        gap_max = 0;
        repeat (150) send_random_item();
        drain_requests();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 5; phase++) begin
            apply_settings(16'($urandom_range(30000, 65535)), 6'($urandom),
                           24'($urandom), 24'($urandom));
            gap_max = (phase == 2) ? 0 : $urandom_range(2, 16);
            repeat (280) send_random_item();
            drain_requests();
        end
    endtask

    // receiver stall pattern in one of four randomly chosen modes
    always @(posedge aclk) begin
        rx_cycle <= rx_cycle + 1;
        if (rx_cycle % 256 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= 1'($urandom_range(0, 1));
            end
            2: begin
                m_ready <= (rx_cycle % 5) > 1;
            end
            default: begin
                if (rx_stall > 0) begin
                    rx_stall <= rx_stall - 1;
                    m_ready  <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rx_stall <= $urandom_range(1, 20);
                    m_ready  <= 1'b0;
                end else begin
                    m_ready <= 1'b1;
                end
            end
        endcase
    end

    always @(posedge aclk) begin
        reading_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result with no pending request", m_position, 0);
            end else begin
                want = pending_readings.pop_front();
                if (m_out_channel !== want.chan) begin
                    report_mismatch("channel", m_out_channel, want.chan);
                end
                if (m_position !== want.pos) begin
                    report_mismatch("position", m_position, want.pos);
                end
                if (m_velocity !== want.vel) begin
                    report_mismatch("velocity", m_velocity, want.vel);
                end
                if (m_homed !== want.homed) begin
                    report_mismatch("homed", m_homed, want.homed);
                end
            end
        end
    end

    initial begin
        reset_tracker_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_register_extremes();
        test_random_settings();
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
